// ----- hw/rtl/tfm_pkg.sv -----
// Package for the tuner frequency meter: request and result types, divider
// handshake types, FSM states and the per-string constant tables.
// No dependencies.
package tfm_pkg;

  localparam int unsigned WINDOW_LEN_DEF = 20;

  localparam int unsigned PERIOD_W = 20;
  localparam int unsigned FREQ_W   = 20;
  localparam int unsigned AVG_W    = 9;
  localparam int unsigned STR_W    = 3;
  localparam int unsigned PCT_W    = 8;
  localparam int unsigned LED_W    = 3;
  localparam int unsigned TONE_W   = 9;
  localparam int unsigned FC_W     = 16;
  localparam int unsigned BAND_W   = 19;
  localparam int unsigned F1K_W    = 30;

  // Shared divider: widest dividend is avg * 10000, widest divisor the period
  localparam int unsigned DVD_W = 23;
  localparam int unsigned DVS_W = 20;

  localparam logic [DVD_W-1:0] FreqNumer  = DVD_W'(1000000);
  localparam logic [13:0]      PctScale   = 14'd10000;
  localparam logic [9:0]       KiloScale  = 10'd1000;
  localparam logic [STR_W-1:0] StrFirst   = STR_W'(1);
  localparam logic [STR_W-1:0] StrLast    = STR_W'(6);

  typedef struct packed {
    logic                cmd;
    logic [PERIOD_W-1:0] edge_period;
    logic                button_pressed;
  } tfm_req_t;

  typedef struct packed {
    logic              kind;
    logic [FREQ_W-1:0] freq_hz;
    logic              sample_taken;
    logic [AVG_W-1:0]  avg_hz;
    logic [STR_W-1:0]  string_num;
    logic [PCT_W-1:0]  deviation_pct;
    logic [LED_W-1:0]  led_index;
    logic [TONE_W-1:0] tone_period_us;
  } tfm_rsp_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_FREQ,
    ST_BAND,
    ST_DIV_AVG,
    ST_MUL,
    ST_PCT,
    ST_DIV_PCT,
    ST_OUT
  } state_e;

  // Target frequency in 0.01 Hz; an out-of-range select maps to the lowest string
  function automatic logic [FC_W-1:0] target_fc(input logic [STR_W-1:0] s);
    logic [FC_W-1:0] fc;
    case (s)
      3'd1:    fc = 16'd32963;
      3'd2:    fc = 16'd24694;
      3'd3:    fc = 16'd19600;
      3'd4:    fc = 16'd14683;
      3'd5:    fc = 16'd11000;
      default: fc = 16'd8241;
    endcase
    return fc;
  endfunction

  // floor(2132000 / Fc)
  function automatic logic [TONE_W-1:0] tone_of(input logic [STR_W-1:0] s);
    logic [TONE_W-1:0] t;
    case (s)
      3'd1:    t = 9'd64;
      3'd2:    t = 9'd86;
      3'd3:    t = 9'd108;
      3'd4:    t = 9'd145;
      3'd5:    t = 9'd193;
      default: t = 9'd258;
    endcase
    return t;
  endfunction

  function automatic logic [BAND_W-1:0] band_lo(input logic [STR_W-1:0] s);
    return {target_fc(s), 3'b000};
  endfunction

  function automatic logic [BAND_W-1:0] band_hi(input logic [STR_W-1:0] s);
    return BAND_W'({target_fc(s), 3'b000} + {1'b0, target_fc(s), 2'b00});
  endfunction

  // Seven-position bar; tighter bins on the three high strings
  function automatic logic [LED_W-1:0] led_grade(input logic [PCT_W-1:0] p,
                                                 input logic [STR_W-1:0] s);
    logic [PCT_W-1:0] a_lo, b_lo, c_lo, c_hi, b_hi, a_hi;
    logic [LED_W-1:0] led;
    if (s <= 3'd3) begin
      a_lo = 8'd95; b_lo = 8'd97; c_lo = 8'd99;
      c_hi = 8'd101; b_hi = 8'd103; a_hi = 8'd105;
    end else begin
      a_lo = 8'd90; b_lo = 8'd94; c_lo = 8'd98;
      c_hi = 8'd102; b_hi = 8'd106; a_hi = 8'd110;
    end
    if (p <= a_lo)      led = 3'd0;
    else if (p <= b_lo) led = 3'd1;
    else if (p <= c_lo) led = 3'd2;
    else if (p <= c_hi) led = 3'd3;
    else if (p <= b_hi) led = 3'd4;
    else if (p <= a_hi) led = 3'd5;
    else                led = 3'd6;
    return led;
  endfunction

endpackage

// ----- hw/rtl/tfm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tfm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/tfm_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on tfm_pkg for widths and the request/response structs.
module tfm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tfm_pkg::div_req_t req_i,
  output tfm_pkg::div_rsp_t rsp_o
);
  import tfm_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [DVS_W:0]   shifted;
  logic [DVS_W+1:0] diff;

  assign shifted = {rem_q, quo_q[DVD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d = req_i.dividend;
      rem_d = '0;
      dvs_d = req_i.divisor;
      cnt_d = CNT_W'(DVD_W);
    end else if (cnt_q != '0) begin
      // keep the partial remainder when the trial subtract goes negative
      rem_d  = diff[DVS_W+1] ? shifted[DVS_W-1:0] : diff[DVS_W-1:0];
      quo_d  = {quo_q[DVD_W-2:0], ~diff[DVS_W+1]};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  // remainder must stay below the divisor while a divide runs
  a_rem_lt_dvs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) && !req_i.start |-> rem_q < dvs_q)
    else $error("divider remainder not below divisor");

  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(cnt_q) == CNT_W'(1))
    else $error("divider done without last step");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> cnt_q == '0)
    else $error("divider restarted while busy");

endmodule

// ----- hw/rtl/tuner_frequency_meter.sv -----
// Tuner frequency meter top: control FSM, sample window with running sum.
// Depends on tfm_pkg, tfm_div and tfm_ram.
//
//  channel | signals                          | payload
//  --------+----------------------------------+------------------------------
//  in      | in_valid_i / in_ready_o          | in_req_i  (edge or tick)
//  out     | out_valid_o / out_ready_i        | out_rsp_o (one result each)
//
// Edge request: bit-serial divide (skipped for period zero), then ST_BAND and
// ST_OUT. Tick request: two divider passes (sum / window, then percent). One
// request is worked at a time; a new one is taken once the previous result sits
// in the output register, so a stalled output holds only the following result.
// Reset clears the window valid bits, write position, sum and selects string 1;
// no clearing pass.
module tuner_frequency_meter #(
  parameter int unsigned WINDOW_LEN = tfm_pkg::WINDOW_LEN_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tfm_pkg::tfm_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tfm_pkg::tfm_rsp_t out_rsp_o
);
  import tfm_pkg::*;

  localparam int unsigned POS_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned SUM_W = $clog2(WINDOW_LEN * 511 + 1);
  localparam int unsigned PROD_W = DVD_W;

  state_e state_q, state_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                  btn_q;
  logic [STR_W-1:0]      str_q;
  logic [POS_W-1:0]      wpos_q;
  logic [SUM_W-1:0]      sum_q;
  logic [WINDOW_LEN-1:0] vld_q;
  logic                  vld_rd_q;
  logic [FREQ_W-1:0]     freq_q;
  logic [F1K_W-1:0]      f1k_q;
  logic [AVG_W-1:0]      avg_q;
  logic [TONE_W-1:0]     tone_q;
  logic [PROD_W-1:0]     prod_q;
  tfm_rsp_t              res_q;
  tfm_rsp_t              out_q;
  logic                  out_valid_q;

  logic             accept;
  logic             zero_period;
  logic             taken;
  logic             ram_we;
  logic             load_out;
  logic [AVG_W-1:0] ram_rdata;
  logic [AVG_W-1:0] old_smp;
  logic [AVG_W-1:0] avg_sat;
  logic [PCT_W-1:0] pct_sat;

  assign accept      = in_valid_i && in_ready_o;
  assign zero_period = (in_req_i.edge_period == '0);
  assign taken       = (f1k_q > F1K_W'(band_lo(str_q))) && (f1k_q < F1K_W'(band_hi(str_q)));
  assign old_smp     = vld_rd_q ? ram_rdata : '0;
  assign avg_sat     = (|div_rsp.quotient[DVD_W-1:AVG_W]) ? '1 : div_rsp.quotient[AVG_W-1:0];
  assign pct_sat     = (|div_rsp.quotient[DVD_W-1:PCT_W]) ? '1 : div_rsp.quotient[PCT_W-1:0];
  assign load_out    = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_req_i.cmd)     state_d = ST_DIV_AVG;
          else if (zero_period) state_d = ST_BAND;
          else                  state_d = ST_DIV_FREQ;
        end
      end
      ST_DIV_FREQ: if (div_rsp.done) state_d = ST_BAND;
      ST_BAND:     state_d = ST_OUT;
      ST_DIV_AVG:  if (div_rsp.done) state_d = ST_MUL;
      ST_MUL:      state_d = ST_PCT;
      ST_PCT:      state_d = ST_DIV_PCT;
      ST_DIV_PCT:  if (div_rsp.done) state_d = ST_OUT;
      ST_OUT:      if (load_out) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Outputs of the FSM
  always_comb begin
    in_ready_o       = 1'b0;
    ram_we           = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = FreqNumer;
    div_req.divisor  = in_req_i.edge_period;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_req_i.cmd) begin
          div_req.dividend = DVD_W'(sum_q);
          div_req.divisor  = DVS_W'(WINDOW_LEN);
        end
        div_req.start = in_valid_i && (in_req_i.cmd || !zero_period);
      end
      ST_BAND: ram_we = taken;
      ST_PCT: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_q;
        div_req.divisor  = DVS_W'(target_fc(str_q));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      str_q       <= StrFirst;
      wpos_q      <= '0;
      sum_q       <= '0;
      vld_q       <= '0;
      vld_rd_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      vld_rd_q <= vld_q[wpos_q];
      if (state_q == ST_BAND) begin
        if (taken) begin
          sum_q         <= sum_q - SUM_W'(old_smp) + SUM_W'(freq_q[AVG_W-1:0]);
          vld_q[wpos_q] <= 1'b1;
        end
        // advance on every edge, stored or not
        wpos_q <= (wpos_q == POS_W'(WINDOW_LEN - 1)) ? '0 : wpos_q + 1'b1;
      end
      if ((state_q == ST_DIV_AVG) && div_rsp.done && btn_q) begin
        str_q <= (str_q == StrLast) ? StrFirst : str_q + 1'b1;
      end
      if (load_out)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      btn_q  <= in_req_i.button_pressed;
      freq_q <= '0;
      f1k_q  <= '0;
    end
    if ((state_q == ST_DIV_FREQ) && div_rsp.done) begin
      freq_q <= div_rsp.quotient[FREQ_W-1:0];
      f1k_q  <= F1K_W'(div_rsp.quotient[FREQ_W-1:0]) * F1K_W'(KiloScale);
    end
    if ((state_q == ST_DIV_AVG) && div_rsp.done) begin
      avg_q  <= avg_sat;
      tone_q <= tone_of(str_q);
    end
    if (state_q == ST_MUL) begin
      prod_q <= PROD_W'(avg_q) * PROD_W'(PctScale);
    end
    if (state_q == ST_BAND) begin
      res_q <= '{kind: 1'b0, freq_hz: freq_q, sample_taken: taken, avg_hz: '0,
                 string_num: str_q, deviation_pct: '0, led_index: '0,
                 tone_period_us: '0};
    end
    if ((state_q == ST_DIV_PCT) && div_rsp.done) begin
      res_q <= '{kind: 1'b1, freq_hz: '0, sample_taken: 1'b0, avg_hz: avg_q,
                 string_num: str_q, deviation_pct: pct_sat,
                 led_index: led_grade(pct_sat, str_q), tone_period_us: tone_q};
    end
    if (load_out) begin
      out_q <= res_q;
    end
  end

  tfm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  tfm_ram #(
    .WIDTH (AVG_W),
    .DEPTH (WINDOW_LEN)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wpos_q),
    .wdata_i (freq_q[AVG_W-1:0]),
    .raddr_i (wpos_q),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV_FREQ) || (state_q == ST_DIV_AVG) ||
                     (state_q == ST_DIV_PCT))
    else $error("divider finished outside a wait state");

  a_string_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (str_q >= StrFirst) && (str_q <= StrLast))
    else $error("string select out of range");

  a_wpos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wpos_q < POS_W'(WINDOW_LEN - 1) || wpos_q == POS_W'(WINDOW_LEN - 1))
    else $error("write position beyond window");

  a_taken_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.sample_taken |-> !out_rsp_o.kind && (out_rsp_o.freq_hz != '0))
    else $error("stored sample on a tick or at zero frequency");

  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> sum_q <= SUM_W'(WINDOW_LEN * 511))
    else $error("running sum exceeds window bound");

endmodule
